>>> design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the address range prefix cover
// Holds the beat formats of both channels and the entry format of the
// queue between the front and back parts.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ADDR_BITS       = 32;
    localparam int CNT_W           = 16;
    localparam int LEN_W           = 6;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QDEPTH          = 2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start_address;
        logic [CNT_W-1:0]     address_count;
    } t_range_in;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix_address;
        logic [LEN_W-1:0]     prefix_length;
        logic                 last_block;
        logic                 range_clipped;
    } t_block_out;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [CNT_W-1:0]     remain;
        logic                 clipped;
    } t_range_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> design/arpc_front.sv
// ----------------------------------------------------------------------------
// arpc_front: input side of the prefix cover
// Accepts range beats, masks the count, clips the range at the top address
// and pushes a job into the queue. Empty ranges are taken and dropped.
// ----------------------------------------------------------------------------
module arpc_front
    import arpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_range_in     i_in_data,
    input  t_queue_status i_qstat,
    output logic          o_push,
    output t_range_job    o_job
);

    localparam int CW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    logic [CNT_W-1:0]     cnt;
    logic [ADDR_BITS:0]   sum;
    logic [ADDR_BITS-1:0] to_top;
    logic                 clip;

    always_comb begin
        cnt    = CNT_W'(i_in_data.address_count[CW-1:0]);
        sum    = {1'b0, i_in_data.start_address} + (ADDR_BITS+1)'(cnt);
        clip   = sum[ADDR_BITS] && (sum[ADDR_BITS-1:0] != '0);
        to_top = '0 - i_in_data.start_address;

        o_in_ready      = !i_qstat.full;
        o_push          = i_in_valid && o_in_ready && (cnt != '0);
        o_job.start     = i_in_data.start_address;
        o_job.remain    = clip ? to_top[CNT_W-1:0] : cnt;
        o_job.clipped   = clip;
    end

endmodule

>>> design/arpc_queue.sv
// ----------------------------------------------------------------------------
// arpc_queue: short job queue between front and back
// A two-entry first-in first-out store that decouples the input handshake
// from the block sequencer.
// ----------------------------------------------------------------------------
module arpc_queue
    import arpc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_range_job    i_job,
    input  logic          i_pop,
    output t_range_job    o_head,
    output t_queue_status o_stat
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FW = $clog2(QDEPTH + 1);

    t_range_job    r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;

    always_comb begin
        o_stat.full  = (r_fill == FW'(QDEPTH));
        o_stat.empty = (r_fill == '0);
        o_head       = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

>>> design/arpc_back.sv
// ----------------------------------------------------------------------------
// arpc_back: block sequencer of the prefix cover
// Takes one job at a time from the queue and emits one aligned prefix block
// per cycle into a registered output stage while that stage is free or read,
// largest first that fits the current address alignment and remaining count.
// ----------------------------------------------------------------------------
module arpc_back
    import arpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_range_job    i_head,
    input  t_queue_status i_qstat,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_block_out    o_out_data
);

    localparam int CW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam int KW = $clog2(CW + 1);

    logic                 r_active, n_active;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [CW-1:0]        r_rem, n_rem;
    logic                 r_clip, n_clip;
    logic                 r_out_valid, n_out_valid;
    t_block_out           r_out, n_out;

    logic [KW-1:0]        tz;
    logic [KW-1:0]        msb;
    logic [KW-1:0]        k;
    logic [CW-1:0]        size;
    logic                 emit;
    logic                 last;

    always_comb begin
        tz = KW'(CW - 1);
        for (int i = CW - 1; i >= 0; i--) begin
            if (r_addr[i]) begin
                tz = KW'(i);
            end
        end
        msb = '0;
        for (int j = 0; j < CW; j++) begin
            if (r_rem[j]) begin
                msb = KW'(j);
            end
        end
        k    = (tz < msb) ? tz : msb;
        size = CW'(1) << k;
        last = (r_rem == size);
        emit = r_active && (!r_out_valid || i_out_ready);
        o_pop = !r_active && !i_qstat.empty;

        n_active    = r_active;
        n_addr      = r_addr;
        n_rem       = r_rem;
        n_clip      = r_clip;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (emit) begin
            n_out.prefix_address = r_addr;
            n_out.prefix_length  = LEN_W'(ADDR_BITS) - LEN_W'(k);
            n_out.last_block     = last;
            n_out.range_clipped  = r_clip;
            n_out_valid          = 1'b1;
            n_addr               = r_addr + ADDR_BITS'(size);
            n_rem                = r_rem - size;
            n_active             = !last;
        end else if (o_pop) begin
            n_active = 1'b1;
            n_addr   = i_head.start;
            n_rem    = i_head.remain[CW-1:0];
            n_clip   = i_head.clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_rem  <= n_rem;
        r_clip <= n_clip;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/address_range_to_prefix_cover_top.sv
// Flow: with the back part idle, an accepted range is written into the queue,
// popped into the sequencer registers, then its first block is registered.
// Throughput: a range is loaded, then one block per cycle while the output
// is ready (at most 30 blocks per range), set by the back part sequencer.
// The two-entry job queue takes new ranges while a range is being emitted.
// Synchronous active-low reset empties the queue and the output stage.
// ----------------------------------------------------------------------------
// address_range_to_prefix_cover_top: address range to prefix block cover
// Turns a start address and an address count into the minimal ascending
// list of aligned prefix blocks, clipped at the top address.
// ----------------------------------------------------------------------------
module address_range_to_prefix_cover_top
    import arpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_range_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_block_out o_out_data
);

    t_queue_status qstat;
    t_range_job    push_job;
    t_range_job    head_job;
    logic          push;
    logic          pop;

    arpc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    arpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (qstat)
    );

    arpc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the prefix cover
// Watches the result channel for stalled beats, block alignment, block size
// and the state after reset.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_block_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result beat changed.");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.prefix_address & (32'hFFFF_FFFF >> o_out_data.prefix_length))
             == '0))
        else $error("Block base address is not aligned to its length.");

    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.prefix_length <= LEN_W'(ADDR_BITS)) &&
            (o_out_data.prefix_length >= LEN_W'(ADDR_BITS - CNT_W + 1)))
        else $error("Block length out of range.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result beat valid straight after reset.");

endmodule

bind address_range_to_prefix_cover_top arpc_checker u_arpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
